// ===== rtl/phdq_pkg.sv =====
// ----------------------------------------------------------------------------
// phdq_pkg
// Shared types and constants for the phased delay injection queue.
// ----------------------------------------------------------------------------
package phdq_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 32;
   localparam int MAX_RESULTS         = 32;
   localparam int RESULT_CNT_WIDTH    = $clog2(MAX_RESULTS + 1);

   // serialization rate, and the reciprocal used instead of a divider
   localparam int BYTES_PER_MS     = 125;
   localparam int BYTE_RECIP_SHIFT = 23;
   localparam int BYTE_RECIP       = ((2 ** BYTE_RECIP_SHIFT) + BYTES_PER_MS - 1) / BYTES_PER_MS;

   localparam logic [15:0] WINDOW_START_RESET = 16'd400;
   localparam logic [15:0] WINDOW_END_RESET   = 16'd600;

   localparam int CSR_ADDR_WIDTH  = 5;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam int CSR_INDEX_WIDTH = 3;

   // stored entry: due time, arrival time, handle
   localparam int ENTRY_WIDTH = 32 + 32 + 16;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_DELAY_BUDGET = 3'd0,
      CSR_PULSE_ON     = 3'd1,
      CSR_PULSE_OFF    = 3'd2,
      CSR_WINDOW_START = 3'd3,
      CSR_WINDOW_END   = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [15:0] delay_budget_ms;
      logic [15:0] pulse_on_ms;
      logic [15:0] pulse_off_ms;
      logic [15:0] window_start_ms;
      logic [15:0] window_end_ms;
   } cfg_type;

   typedef enum logic [1:0] {
      EMIT_ARRIVAL = 2'd0,
      EMIT_DROP    = 2'd1,
      EMIT_RELEASE = 2'd2,
      EMIT_EMPTY   = 2'd3
   } emit_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE      = 3'd0,
      ST_ARR_MUL   = 3'd1,
      ST_ARR_DUE   = 3'd2,
      ST_ARR_EMIT  = 3'd3,
      ST_ARR_DROP  = 3'd4,
      ST_POLL_READ = 3'd5,
      ST_POLL_EVAL = 3'd6
   } ctrl_state_type;

   typedef struct packed {
      logic          capture;
      logic          arr_stage1;
      logic          arr_stage2;
      logic          arr_commit;
      logic          pop;
      logic          emit;
      emit_kind_type emit_kind;
      logic          emit_last;
   } dp_cmd_type;

   typedef struct packed {
      logic is_poll;
      logic full;
      logic head_due_ok;
      logic out_free;
   } dp_status_type;

endpackage

// ===== rtl/phdq_req_if.sv =====
// ----------------------------------------------------------------------------
// phdq_req_if
// Request channel: packet arrivals and departure polls.
// ----------------------------------------------------------------------------
interface phdq_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic [31:0] now_ms;
   logic [15:0] packet_bytes;
   logic [15:0] packet_handle;

   modport source (output valid, action, now_ms, packet_bytes, packet_handle, input ready);
   modport sink   (input valid, action, now_ms, packet_bytes, packet_handle, output ready);
endinterface

// ===== rtl/phdq_rsp_if.sv =====
// ----------------------------------------------------------------------------
// phdq_rsp_if
// Response channel: one transaction per result item.
// ----------------------------------------------------------------------------
interface phdq_rsp_if;
   logic        valid;
   logic        ready;
   logic        departs;
   logic [15:0] out_handle;
   logic [31:0] arrived_ms;
   logic [31:0] sojourn_ms;
   logic [31:0] due_ms;
   logic        dropped;
   logic [15:0] wait_ms;
   logic        last;

   modport source (output valid, departs, out_handle, arrived_ms, sojourn_ms, due_ms,
                   dropped, wait_ms, last, input ready);
   modport sink   (input valid, departs, out_handle, arrived_ms, sojourn_ms, due_ms,
                   dropped, wait_ms, last, output ready);
endinterface

// ===== rtl/phased_delay_injection_queue_core.sv =====
// ----------------------------------------------------------------------------
// phased_delay_injection_queue_core
// Link emulator queue that assigns each packet a due time by phase
// (serialization window, then periodic delay pulses) and releases due
// packets in arrival order on polls.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake                 | carries
//  ----------+-----------+---------------------------+---------------------------
//  req_ch    | in        | valid/ready               | arrival or poll, time, size
//  rsp_ch    | out       | valid/ready               | one result per transaction
//  apb (p*)  | in        | psel/penable, pready = 1  | five 16-bit settings
//
//  an arrival steps through capture, reciprocal multiply for the
//    125 bytes/ms division, due time add, then commit and respond
//  a poll alternates a read state and an evaluate state per released packet: the head is read from
//    the entry ram (registered read) once per release, at most 32 per poll
//  reset is synchronous; queue entries are not cleared, the fill count guards them
//  a stalled response holds the sequencer in place; the next request is
//    taken only once the last result is in the response register
// ----------------------------------------------------------------------------
module phased_delay_injection_queue_core import phdq_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   phdq_req_if.sink                  req_ch,
   phdq_rsp_if.source                rsp_ch,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready
);

   cfg_type       cfg;
   dp_cmd_type    cmd;
   dp_status_type status;

   // register bank
   phdq_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // sequencer: owns request acceptance and the per-poll release count
   phdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // storage, arithmetic and the response register
   phdq_dp #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .req_action        (req_ch.action),
      .req_now_ms        (req_ch.now_ms),
      .req_packet_bytes  (req_ch.packet_bytes),
      .req_packet_handle (req_ch.packet_handle),
      .cmd               (cmd),
      .status            (status),
      .rsp_ready         (rsp_ch.ready),
      .rsp_valid         (rsp_ch.valid),
      .rsp_departs       (rsp_ch.departs),
      .rsp_out_handle    (rsp_ch.out_handle),
      .rsp_arrived_ms    (rsp_ch.arrived_ms),
      .rsp_sojourn_ms    (rsp_ch.sojourn_ms),
      .rsp_due_ms        (rsp_ch.due_ms),
      .rsp_dropped       (rsp_ch.dropped),
      .rsp_wait_ms       (rsp_ch.wait_ms),
      .rsp_last          (rsp_ch.last)
   );

endmodule

// ===== rtl/phdq_ram.sv =====
// ----------------------------------------------------------------------------
// phdq_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module phdq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/phdq_csr.sv =====
// ----------------------------------------------------------------------------
// phdq_csr
// APB-style register bank for the delay and window settings.
// ----------------------------------------------------------------------------
module phdq_csr import phdq_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready,
   output cfg_type                   cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   csr_index_type index;
   logic          wr_en;

   assign index  = csr_index_type'(paddr[CSR_ADDR_WIDTH-1:2]);
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      prdata = '0;
      unique case (index)
         CSR_DELAY_BUDGET: begin
            prdata = CSR_DATA_WIDTH'(cfg_ff.delay_budget_ms);
            if (wr_en) cfg_in.delay_budget_ms = pwdata[15:0];
         end
         CSR_PULSE_ON: begin
            prdata = CSR_DATA_WIDTH'(cfg_ff.pulse_on_ms);
            if (wr_en) cfg_in.pulse_on_ms = pwdata[15:0];
         end
         CSR_PULSE_OFF: begin
            prdata = CSR_DATA_WIDTH'(cfg_ff.pulse_off_ms);
            if (wr_en) cfg_in.pulse_off_ms = pwdata[15:0];
         end
         CSR_WINDOW_START: begin
            prdata = CSR_DATA_WIDTH'(cfg_ff.window_start_ms);
            if (wr_en) cfg_in.window_start_ms = pwdata[15:0];
         end
         CSR_WINDOW_END: begin
            prdata = CSR_DATA_WIDTH'(cfg_ff.window_end_ms);
            if (wr_en) cfg_in.window_end_ms = pwdata[15:0];
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.delay_budget_ms <= '0;
         cfg_ff.pulse_on_ms     <= '0;
         cfg_ff.pulse_off_ms    <= '0;
         cfg_ff.window_start_ms <= WINDOW_START_RESET;
         cfg_ff.window_end_ms   <= WINDOW_END_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/phdq_ctrl.sv =====
// ----------------------------------------------------------------------------
// phdq_ctrl
// Sequencer: steps arrivals through the due-time pipeline and walks polls
// over the queue head one entry at a time.
// ----------------------------------------------------------------------------
module phdq_ctrl import phdq_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   ctrl_state_type              state_ff, state_in;
   logic [RESULT_CNT_WIDTH-1:0] count_ff, count_in;
   logic                        pend_ff, pend_in;
   logic                        release_ok;

   // stop releasing once the per-poll cap is reached
   assign release_ok = status.head_due_ok &&
                       (count_ff < RESULT_CNT_WIDTH'(MAX_RESULTS));

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      pend_in   = pend_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            count_in  = '0;
            pend_in   = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_ARR_MUL;
            end
         end
         ST_ARR_MUL: begin
            if (status.is_poll) begin
               state_in = ST_POLL_EVAL;
            end else if (status.full) begin
               state_in = ST_ARR_DROP;
            end else begin
               cmd.arr_stage1 = 1'b1;
               state_in       = ST_ARR_DUE;
            end
         end
         ST_ARR_DUE: begin
            cmd.arr_stage2 = 1'b1;
            state_in       = ST_ARR_EMIT;
         end
         ST_ARR_EMIT: begin
            if (status.out_free) begin
               cmd.emit       = 1'b1;
               cmd.emit_kind  = EMIT_ARRIVAL;
               cmd.arr_commit = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_ARR_DROP: begin
            if (status.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = EMIT_DROP;
               state_in      = ST_IDLE;
            end
         end
         ST_POLL_READ: begin
            // head entry moved, let the ram read settle
            state_in = ST_POLL_EVAL;
         end
         ST_POLL_EVAL: begin
            if (status.out_free || (!pend_ff && release_ok)) begin
               if (pend_ff) begin
                  cmd.emit      = 1'b1;
                  cmd.emit_kind = EMIT_RELEASE;
                  cmd.emit_last = !release_ok;
               end else if (!release_ok) begin
                  cmd.emit      = 1'b1;
                  cmd.emit_kind = EMIT_EMPTY;
               end
               if (release_ok) begin
                  cmd.pop  = 1'b1;
                  pend_in  = 1'b1;
                  count_in = count_ff + 1'b1;
                  state_in = ST_POLL_READ;
               end else begin
                  pend_in  = 1'b0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

endmodule

// ===== rtl/phdq_dp.sv =====
// ----------------------------------------------------------------------------
// phdq_dp
// Datapath: queue storage and pointers, due-time arithmetic, pulse and
// remainder state, and the response register.
// ----------------------------------------------------------------------------
module phdq_dp import phdq_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  logic          req_action,
   input  logic [31:0]   req_now_ms,
   input  logic [15:0]   req_packet_bytes,
   input  logic [15:0]   req_packet_handle,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   input  logic          rsp_ready,
   output logic          rsp_valid,
   output logic          rsp_departs,
   output logic [15:0]   rsp_out_handle,
   output logic [31:0]   rsp_arrived_ms,
   output logic [31:0]   rsp_sojourn_ms,
   output logic [31:0]   rsp_due_ms,
   output logic          rsp_dropped,
   output logic [15:0]   rsp_wait_ms,
   output logic          rsp_last
);

   localparam int PTR_WIDTH   = $clog2(QUEUE_DEPTH);
   localparam int CNT_WIDTH   = $clog2(QUEUE_DEPTH + 1);
   localparam int TOTAL_WIDTH = 17;
   localparam int PROD_WIDTH  = 34;
   localparam int QUOT_WIDTH  = PROD_WIDTH - BYTE_RECIP_SHIFT;
   localparam int REM_WIDTH   = 7;
   localparam logic [15:0] WAIT_NONE = 16'hFFFF;

   function automatic logic [PTR_WIDTH-1:0] ptr_next(input logic [PTR_WIDTH-1:0] ptr);
      return (ptr == PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
   endfunction

   function automatic logic [31:0] sat32(input logic [32:0] value);
      return value[32] ? 32'hFFFF_FFFF : value[31:0];
   endfunction

   function automatic logic [15:0] wait_of(input logic        valid,
                                           input logic [31:0] due,
                                           input logic [31:0] now);
      logic [31:0] diff;
      diff = due - now;
      if (!valid) return WAIT_NONE;
      if (due <= now) return 16'd0;
      if (diff > 32'h0000_FFFF) return WAIT_NONE;
      return diff[15:0];
   endfunction

   // captured request
   logic        action_ff;
   logic [31:0] now_ff;
   logic [15:0] bytes_ff;
   logic [15:0] handle_ff;

   // queue state
   logic [PTR_WIDTH-1:0] head_ff, tail_ff;
   logic [CNT_WIDTH-1:0] count_ff;
   logic [31:0]          last_due_ff;
   logic [31:0]          pulse_start_ff;
   logic [REM_WIDTH-1:0] rem_ff;

   // arrival pipeline
   logic [TOTAL_WIDTH-1:0] total_ff;
   logic [PROD_WIDTH-1:0]  prod_ff;
   logic                   win_ff, late_ff, newp_ff, onp_ff;
   logic [31:0]            due_ff;
   logic [REM_WIDTH-1:0]   rem_next_ff;
   logic                   pulse_set_ff;

   // released entry waiting for the response register
   logic [15:0] pend_handle_ff;
   logic [31:0] pend_arr_ff;
   logic [31:0] pend_soj_ff;

   // response register
   logic        rsp_valid_ff;
   logic        departs_ff;
   logic [15:0] out_handle_ff;
   logic [31:0] arrived_ff;
   logic [31:0] sojourn_ff;
   logic [31:0] due_ms_ff;
   logic        dropped_ff;
   logic [15:0] wait_ff;
   logic        last_ff;

   // ram
   logic [ENTRY_WIDTH-1:0] ram_wr_data, ram_rd_data;
   logic [31:0]            head_due, head_arr;
   logic [15:0]            head_handle;

   phdq_ram #(
      .WIDTH (ENTRY_WIDTH),
      .DEPTH (QUEUE_DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (cmd.arr_commit),
      .wr_addr (tail_ff),
      .wr_data (ram_wr_data),
      .rd_addr (head_ff),
      .rd_data (ram_rd_data)
   );

   assign ram_wr_data = {due_ff, now_ff, handle_ff};
   assign head_due    = ram_rd_data[79:48];
   assign head_arr    = ram_rd_data[47:16];
   assign head_handle = ram_rd_data[15:0];

   // stage 1: byte total, reciprocal product, phase decisions
   logic [TOTAL_WIDTH-1:0] total_w;
   logic [PROD_WIDTH-1:0]  prod_w;
   logic [31:0]            since_w;
   logic [16:0]            period_w;

   assign total_w  = TOTAL_WIDTH'(rem_ff) + TOTAL_WIDTH'(bytes_ff);
   assign prod_w   = PROD_WIDTH'(total_w) * PROD_WIDTH'(BYTE_RECIP);
   assign since_w  = now_ff - pulse_start_ff;
   assign period_w = 17'(cfg.pulse_on_ms) + 17'(cfg.pulse_off_ms);

   // stage 2: quotient fixup and due time
   logic [QUOT_WIDTH-1:0]  quot_raw_w, quot_w;
   logic [TOTAL_WIDTH-1:0] rem_raw_w, rem_w;
   logic [31:0]            base_w;
   logic [15:0]            delay_w;
   logic [31:0]            due_w;

   always_comb begin
      quot_raw_w = QUOT_WIDTH'(prod_ff >> BYTE_RECIP_SHIFT);
      rem_raw_w  = total_ff - TOTAL_WIDTH'(TOTAL_WIDTH'(quot_raw_w) *
                                           TOTAL_WIDTH'(BYTES_PER_MS));
      if (rem_raw_w >= TOTAL_WIDTH'(BYTES_PER_MS)) begin
         quot_w = quot_raw_w + 1'b1;
         rem_w  = rem_raw_w - TOTAL_WIDTH'(BYTES_PER_MS);
      end else begin
         quot_w = quot_raw_w;
         rem_w  = rem_raw_w;
      end
      base_w  = ((count_ff != '0) && (last_due_ff > now_ff)) ? last_due_ff : now_ff;
      delay_w = (newp_ff || onp_ff) ? cfg.delay_budget_ms : 16'd0;
      if (win_ff) begin
         due_w = sat32(33'(base_w) + 33'(quot_w));
      end else if (late_ff) begin
         due_w = sat32(33'(now_ff) + 33'(delay_w));
      end else begin
         due_w = now_ff;
      end
   end

   // wait for the response: head after this transaction
   logic        wait_valid_w;
   logic [31:0] wait_due_w;
   logic [15:0] wait_w;

   always_comb begin
      wait_valid_w = (count_ff != '0);
      wait_due_w   = head_due;
      if ((cmd.emit_kind == EMIT_ARRIVAL) && (count_ff == '0)) begin
         wait_valid_w = 1'b1;
         wait_due_w   = due_ff;
      end
      wait_w = wait_of(wait_valid_w, wait_due_w, now_ff);
   end

   assign status.is_poll     = action_ff;
   assign status.full        = (count_ff == CNT_WIDTH'(QUEUE_DEPTH));
   assign status.head_due_ok = (count_ff != '0) && (head_due <= now_ff);
   assign status.out_free    = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff <= req_action;
         now_ff    <= req_now_ms;
         bytes_ff  <= req_packet_bytes;
         handle_ff <= req_packet_handle;
      end
      if (cmd.arr_stage1) begin
         total_ff <= total_w;
         prod_ff  <= prod_w;
         win_ff   <= (now_ff > 32'(cfg.window_start_ms)) &&
                     (now_ff < 32'(cfg.window_end_ms));
         late_ff  <= (now_ff >= 32'(cfg.window_end_ms));
         newp_ff  <= (since_w > 32'(period_w));
         onp_ff   <= (since_w < 32'(cfg.pulse_on_ms));
      end
      if (cmd.arr_stage2) begin
         due_ff       <= due_w;
         rem_next_ff  <= rem_w[REM_WIDTH-1:0];
         pulse_set_ff <= win_ff || (late_ff && newp_ff);
      end
      if (cmd.pop) begin
         pend_handle_ff <= head_handle;
         pend_arr_ff    <= head_arr;
         pend_soj_ff    <= now_ff - head_arr;
      end
      if (cmd.emit) begin
         departs_ff    <= 1'b0;
         out_handle_ff <= '0;
         arrived_ff    <= '0;
         sojourn_ff    <= '0;
         due_ms_ff     <= '0;
         dropped_ff    <= 1'b0;
         wait_ff       <= wait_w;
         last_ff       <= 1'b1;
         case (cmd.emit_kind)
            EMIT_ARRIVAL: due_ms_ff <= due_ff;
            EMIT_DROP:    dropped_ff <= 1'b1;
            EMIT_RELEASE: begin
               departs_ff    <= 1'b1;
               out_handle_ff <= pend_handle_ff;
               arrived_ff    <= pend_arr_ff;
               sojourn_ff    <= pend_soj_ff;
               last_ff       <= cmd.emit_last;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff        <= '0;
         tail_ff        <= '0;
         count_ff       <= '0;
         last_due_ff    <= '0;
         pulse_start_ff <= '0;
         rem_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (cmd.arr_commit) begin
            tail_ff     <= ptr_next(tail_ff);
            count_ff    <= count_ff + 1'b1;
            last_due_ff <= due_ff;
            if (win_ff) rem_ff <= rem_next_ff;
            if (pulse_set_ff) pulse_start_ff <= now_ff;
         end else if (cmd.pop) begin
            head_ff  <= ptr_next(head_ff);
            count_ff <= count_ff - 1'b1;
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_departs    = departs_ff;
   assign rsp_out_handle = out_handle_ff;
   assign rsp_arrived_ms = arrived_ff;
   assign rsp_sojourn_ms = sojourn_ff;
   assign rsp_due_ms     = due_ms_ff;
   assign rsp_dropped    = dropped_ff;
   assign rsp_wait_ms    = wait_ff;
   assign rsp_last       = last_ff;

endmodule
